### design/urc_pkg.sv
// shared types and constants for the udp receive checker
// no dependencies; imported by every module of the block
`default_nettype none

package urc_pkg;

	localparam int unsigned URC_QUEUE_DEPTH   = 4;
	localparam logic [15:0] URC_MAX_LEN_RESET = 16'd1008;
	localparam logic [14:0] URC_INDEX_LIMIT   = 15'h7fff;
	localparam logic [3:0]  URC_MIN_IHL       = 4'd5;
	localparam logic [15:0] URC_UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] URC_ALL_ONES      = 16'hffff;
	localparam logic [15:0] URC_HIGH_BYTE     = 16'hff00;
	localparam logic [15:0] URC_LOW_BYTE      = 16'h00ff;

	// what the back end does with one packet word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_PROTO,
		OP_SRC_HI,
		OP_SRC_LO,
		OP_DST_HI,
		OP_DST_LO,
		OP_SPORT,
		OP_DPORT,
		OP_ULEN,
		OP_CSUM,
		OP_ADD,
		OP_ADD_HI
	} urc_op_t;

	typedef enum logic [1:0] {
		VERDICT_OK       = 2'd0,
		VERDICT_MISMATCH = 2'd1,
		VERDICT_DISCARD  = 2'd2
	} urc_verdict_t;

	// classified item passed from front to back
	typedef struct packed {
		urc_op_t     op;
		logic [15:0] word;
		logic        last;
		logic [15:0] dlen;
	} urc_item_t;

	// header fields captured for one packet
	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] ulen;
		logic [15:0] csum;
	} urc_fields_t;

endpackage

`default_nettype wire

### design/urc_front.sv
// front end: tracks word position in the packet and classifies each item
// depends on urc_pkg
`default_nettype none

module urc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [15:0]         packet_word,
	input  wire                 last_word,
	input  wire                 in_valid,
	output logic                in_ready,
	output urc_pkg::urc_item_t  push_item,
	output logic                push_valid,
	input  wire                 push_ready
);
	import urc_pkg::*;

	logic [14:0] idx_q;
	logic [3:0]  hw_q;
	logic [15:0] dlen_q;

	logic        accept;
	logic [3:0]  ihl;
	logic [3:0]  hw_nx;
	logic [15:0] dlen_nx;
	logic [14:0] idx_nx;
	logic [4:0]  udp_start;
	logic [15:0] hdr_bytes;
	logic [14:0] k;
	logic [15:0] odd_byte;
	urc_op_t     op;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	assign ihl       = packet_word[11:8];
	assign udp_start = {hw_q, 1'b0};
	assign hdr_bytes = {10'd0, hw_q, 2'b00};
	assign k         = idx_q - {10'd0, udp_start};
	// offset of the second byte of data word k within the udp part
	assign odd_byte  = {k, 1'b1};

	always_comb begin
		op      = OP_NONE;
		hw_nx   = hw_q;
		dlen_nx = dlen_q;
		unique case (idx_q)
			15'd0: begin
				op      = OP_START;
				hw_nx   = (ihl < URC_MIN_IHL) ? URC_MIN_IHL : ihl;
				dlen_nx = '0;
			end
			15'd1: begin
				dlen_nx = (packet_word >= hdr_bytes) ? (packet_word - hdr_bytes) : '0;
			end
			15'd4: op = OP_PROTO;
			15'd6: op = OP_SRC_HI;
			15'd7: op = OP_SRC_LO;
			15'd8: op = OP_DST_HI;
			15'd9: op = OP_DST_LO;
			default: begin
				if (idx_q >= {10'd0, udp_start} && idx_q != URC_INDEX_LIMIT) begin
					unique case (k)
						15'd0: op = OP_SPORT;
						15'd1: op = OP_DPORT;
						15'd2: op = OP_ULEN;
						15'd3: op = OP_CSUM;
						default: begin
							if (odd_byte < dlen_q) begin
								op = OP_ADD;
							end else if (odd_byte == dlen_q) begin
								op = OP_ADD_HI;
							end
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin
		if (last_word) begin
			idx_nx = '0;
		end else if (idx_q != URC_INDEX_LIMIT) begin
			idx_nx = idx_q + 15'd1;
		end else begin
			idx_nx = idx_q;
		end
	end

	always_comb begin
		push_item.op   = op;
		push_item.word = packet_word;
		push_item.last = last_word;
		push_item.dlen = dlen_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hw_q   <= '0;
			dlen_q <= '0;
		end else if (accept) begin
			idx_q  <= idx_nx;
			hw_q   <= hw_nx;
			dlen_q <= dlen_nx;
		end
	end

endmodule

`default_nettype wire

### design/urc_queue.sv
// short fifo of classified items between front and back
// depends on urc_pkg
`default_nettype none

module urc_queue #(
	parameter int unsigned Depth = urc_pkg::URC_QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  urc_pkg::urc_item_t  push_item,
	input  wire                 push_valid,
	output logic                push_ready,
	output urc_pkg::urc_item_t  pop_item,
	output logic                pop_valid,
	input  wire                 pop_ready
);
	import urc_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] Full    = CntW'(Depth);

	urc_item_t       mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != Full);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### design/urc_back.sv
// back end: captures fields, accumulates the checksum, and forms the verdict
// depends on urc_pkg
`default_nettype none

module urc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  urc_pkg::urc_item_t  pop_item,
	input  wire                 pop_valid,
	output logic                pop_ready,
	input  wire  [15:0]         max_udp_length,
	output logic [31:0]         source_address,
	output logic [31:0]         dest_address,
	output logic [15:0]         source_port,
	output logic [15:0]         dest_port,
	output logic [15:0]         payload_length,
	output logic [15:0]         computed_sum,
	output logic [1:0]          verdict,
	output logic                out_valid,
	input  wire                 out_ready
);
	import urc_pkg::*;

	urc_fields_t  fld_q;
	logic [31:0]  sum_q;
	urc_fields_t  fld_nx;
	logic [31:0]  sum_nx;
	logic [15:0]  addend;
	logic         take;
	logic         en_s1;
	logic         en_s2;
	logic         en_s3;

	logic         v_s1;
	urc_fields_t  fld_s1;
	logic [31:0]  sum_s1;
	logic [15:0]  dlen_s1;

	logic         v_s2;
	urc_fields_t  fld_s2;
	logic [31:0]  tot_s2;

	logic         v_s3;
	logic [16:0]  fold1;
	logic [15:0]  fold2;
	logic [15:0]  cs;
	urc_verdict_t vd;

	logic [31:0]  src_s3;
	logic [31:0]  dst_s3;
	logic [15:0]  sport_s3;
	logic [15:0]  dport_s3;
	logic [15:0]  plen_s3;
	logic [15:0]  cs_s3;
	urc_verdict_t vd_s3;

	assign en_s3     = !v_s3 || out_ready;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	// a last item needs room in the result pipe, others always flow
	assign pop_ready = !pop_item.last || en_s1;
	assign take      = pop_valid && pop_ready;

	always_comb begin
		fld_nx = fld_q;
		addend = '0;
		unique case (pop_item.op)
			OP_START: fld_nx = '0;
			OP_PROTO: addend = pop_item.word & URC_LOW_BYTE;
			OP_SRC_HI: begin
				fld_nx.src[31:16] = pop_item.word;
				addend            = pop_item.word;
			end
			OP_SRC_LO: begin
				fld_nx.src[15:0] = pop_item.word;
				addend           = pop_item.word;
			end
			OP_DST_HI: begin
				fld_nx.dst[31:16] = pop_item.word;
				addend            = pop_item.word;
			end
			OP_DST_LO: begin
				fld_nx.dst[15:0] = pop_item.word;
				addend           = pop_item.word;
			end
			OP_SPORT: begin
				fld_nx.sport = pop_item.word;
				addend       = pop_item.word;
			end
			OP_DPORT: begin
				fld_nx.dport = pop_item.word;
				addend       = pop_item.word;
			end
			OP_ULEN: begin
				fld_nx.ulen = pop_item.word;
				addend      = pop_item.word;
			end
			OP_CSUM: fld_nx.csum = pop_item.word;
			OP_ADD: addend = pop_item.word;
			OP_ADD_HI: addend = pop_item.word & URC_HIGH_BYTE;
			default: addend = '0;
		endcase
		sum_nx = (pop_item.op == OP_START) ? '0 : (sum_q + {16'd0, addend});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q <= '0;
			sum_q <= '0;
		end else if (take) begin
			fld_q <= fld_nx;
			sum_q <= sum_nx;
		end
	end

	// result pipe: snapshot, add pseudo header length, fold and judge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= take && pop_item.last;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			fld_s1  <= fld_nx;
			sum_s1  <= sum_nx;
			dlen_s1 <= pop_item.dlen;
		end
		if (en_s2) begin
			fld_s2 <= fld_s1;
			tot_s2 <= sum_s1 + {16'd0, dlen_s1};
		end
	end

	always_comb begin
		fold1 = {1'b0, tot_s2[15:0]} + {1'b0, tot_s2[31:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		cs    = ~fold2;
		if (cs == '0) begin
			cs = URC_ALL_ONES;
		end
		if (fld_s2.ulen > max_udp_length) begin
			vd = VERDICT_DISCARD;
		end else if (fld_s2.csum != '0 && cs != fld_s2.csum) begin
			vd = VERDICT_MISMATCH;
		end else begin
			vd = VERDICT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			src_s3   <= fld_s2.src;
			dst_s3   <= fld_s2.dst;
			sport_s3 <= fld_s2.sport;
			dport_s3 <= fld_s2.dport;
			plen_s3  <= (fld_s2.ulen > URC_UDP_HDR_BYTES) ?
				(fld_s2.ulen - URC_UDP_HDR_BYTES) : '0;
			cs_s3    <= cs;
			vd_s3    <= vd;
		end
	end

	assign out_valid      = v_s3;
	assign source_address = src_s3;
	assign dest_address   = dst_s3;
	assign source_port    = sport_s3;
	assign dest_port      = dport_s3;
	assign payload_length = plen_s3;
	assign computed_sum   = cs_s3;
	assign verdict        = vd_s3;

endmodule

`default_nettype wire

### design/udp_receive_checker_top.sv
// top level of the udp receive checker: config register, front, queue, back
// depends on urc_pkg, urc_front, urc_queue, urc_back
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  in        in_valid/in_ready, packet_word, last_word  input
//  cfg       cfg_wr_en, cfg_wr_data (max_udp_length)    input
//  out       out_valid/out_ready, address, port, sum,   output
//            payload_length, verdict fields
//
// one packet word is taken per cycle while the queue has room; the back end also
// retires one item per cycle while a last item finds room in the result stages,
// so throughput is one word per clock while the output is not stalled. a result
// passes the snapshot, length add, and fold and compare stages, each registered.
// output stalls back up through the result stages, then the queue, then in_ready.
// reset clears all control state and loads max_udp_length with 1008.
`default_nettype none

module udp_receive_checker_top #(
	parameter int unsigned QueueDepth = urc_pkg::URC_QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [15:0] packet_word,
	input  wire         last_word,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] payload_length,
	output logic [15:0] computed_sum,
	output logic [1:0]  verdict,
	output logic        out_valid,
	input  wire         out_ready
);
	import urc_pkg::*;

	logic [15:0] max_len_q;
	urc_item_t   push_item;
	logic        push_valid;
	logic        push_ready;
	urc_item_t   pop_item;
	logic        pop_valid;
	logic        pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= URC_MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	urc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.packet_word (packet_word),
		.last_word   (last_word),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.push_item   (push_item),
		.push_valid  (push_valid),
		.push_ready  (push_ready)
	);

	urc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	urc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_item       (pop_item),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.max_udp_length (max_len_q),
		.source_address (source_address),
		.dest_address   (dest_address),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.payload_length (payload_length),
		.computed_sum   (computed_sum),
		.verdict        (verdict),
		.out_valid      (out_valid),
		.out_ready      (out_ready)
	);

endmodule

`default_nettype wire
